[design/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants for the ARP receive and cache block
// Field widths, protocol codes, action codes, register indexes, result word.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;

    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int ENTRY_W   = IP_W + MAC_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;
    localparam int SLOT_W    = 4;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  LEN_MAC     = 8'd6;
    localparam logic [7:0]  LEN_IP      = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 2'd1;

    typedef enum logic [1:0] {
        ACT_DROP    = 2'd0,
        ACT_REPLY   = 2'd1,
        ACT_UPDATED = 2'd2,
        ACT_FULL    = 2'd3
    } action_t;

    typedef struct packed {
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [7:0]       hw_len;
        logic [7:0]       proto_len;
        logic [15:0]      opcode;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
    } item_t;

    typedef struct packed {
        action_t           action;
        logic [MAC_W-1:0]  reply_mac;
        logic [IP_W-1:0]   reply_ip;
        logic [SLOT_W-1:0] slot;
        logic              slot_was_new;
    } result_t;

endpackage

[design/arpc_ram.sv]
// ----------------------------------------------------------------------------
// arpc_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/arpc_ctrl.sv]
// ----------------------------------------------------------------------------
// arpc_ctrl: header check, cache walk and update sequencer
// Walks the entry memory once per accepted reply packet, then writes back at most one entry.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    input  logic [IP_W-1:0]    own_ip,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               mem_rd_en,
    output logic [IDX_W-1:0]   mem_rd_addr,
    input  logic [ENTRY_W-1:0] mem_rd_data,
    output logic               mem_wr_en,
    output logic [IDX_W-1:0]   mem_wr_addr,
    output logic [ENTRY_W-1:0] mem_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     chk_reg, chk_next;
    logic [IDX_W-1:0]         chk_idx_reg, chk_idx_next;
    logic                     hit_reg, hit_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic                     free_reg, free_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    logic [MAC_W-1:0]         smac_reg, smac_next;
    logic [IP_W-1:0]          sip_reg, sip_next;
    result_t                  res_reg, res_next;

    logic hdr_ok;
    logic issue;
    logic entry_v;

    assign hdr_ok = (item.hw_type == HW_ETHERNET) && (item.proto_type == PROTO_IPV4)
                 && (item.hw_len == LEN_MAC) && (item.proto_len == LEN_IP)
                 && (item.target_ip == own_ip);

    assign issue   = (cnt_reg < CNT_W'(CACHE_ENTRIES));
    assign entry_v = valid_reg[chk_idx_reg];

    assign item_ready  = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_FINISH);
    assign res         = res_reg;
    assign mem_rd_en   = (state_reg == ST_SCAN) && issue;
    assign mem_rd_addr = cnt_reg[IDX_W-1:0];
    assign mem_wr_data = {sip_reg, smac_reg};

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        chk_next      = 1'b0;
        chk_idx_next  = chk_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        smac_next     = smac_reg;
        sip_next      = sip_reg;
        res_next      = res_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = hit_reg ? hit_idx_reg : free_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    smac_next = item.sender_mac;
                    sip_next  = item.sender_ip;
                    res_next  = '{ACT_DROP, '0, '0, '0, 1'b0};
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    if (hdr_ok && (item.opcode == OP_REQUEST))
                    begin
                        res_next.action    = ACT_REPLY;
                        res_next.reply_mac = item.sender_mac;
                        res_next.reply_ip  = item.sender_ip;
                        state_next         = ST_FINISH;
                    end
                    else if (hdr_ok && (item.opcode == OP_REPLY))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one read a cycle, judge the entry read the cycle before
                if (issue)
                begin
                    chk_next     = 1'b1;
                    chk_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (chk_reg)
                begin
                    if (entry_v && !hit_reg
                        && (mem_rd_data[ENTRY_W-1 -: IP_W] == sip_reg))
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = chk_idx_reg;
                    end
                    if (!entry_v && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                end
                if (!issue && !chk_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_wr_en  = hit_reg || free_reg;
                state_next = ST_FINISH;
                if (hit_reg)
                begin
                    res_next.action = ACT_UPDATED;
                    res_next.slot   = SLOT_W'(hit_idx_reg);
                end
                else if (free_reg)
                begin
                    res_next.action         = ACT_UPDATED;
                    res_next.slot           = SLOT_W'(free_idx_reg);
                    res_next.slot_was_new   = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                end
                else
                begin
                    res_next.action = ACT_FULL;
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            chk_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            chk_reg   <= chk_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        smac_reg     <= smac_next;
        sip_reg      <= sip_next;
        res_reg      <= res_next;
    end

endmodule

[design/arp_receive_and_cache.sv]
// ----------------------------------------------------------------------------
// arp_receive_and_cache: ARP receive check with an IP-to-MAC neighbor cache
// Validates parsed ARP fields, returns reply targets, maintains the cache.
// ----------------------------------------------------------------------------
// Usage
//   Item channel (item_valid/item_ready): one word holds the parsed fields of
//   one received ARP packet. The block works on one packet at a time and
//   raises item_ready only while no packet is in flight.
//   Result channel (result_valid/result_ready): exactly one word per packet,
//   held in an output register until taken.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0
//   writes own_mac, index 1 writes own_ip, other indexes are ignored.
// Processing
//   Requests and dropped packets: the sequencer goes from accept straight to its finish state.
//   Replies: the walk reads one entry per cycle through the single read port
//   of the entry memory, then writes the chosen entry back if a hit or a
//   free slot was found.
//   A new packet can be accepted as soon as the result enters the output
//   register, even if that word is still waiting.
// Reset
//   Clears all entry valid bits at once; no memory clearing pass is needed.
// Stall
//   A stalled result register holds the finished packet in the sequencer,
//   which then accepts nothing until the word can move.
// ----------------------------------------------------------------------------
module arp_receive_and_cache
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [15:0]          hw_type,
    input  logic [15:0]          proto_type,
    input  logic [7:0]           hw_len,
    input  logic [7:0]           proto_len,
    input  logic [15:0]          opcode,
    input  logic [MAC_W-1:0]     sender_mac,
    input  logic [IP_W-1:0]      sender_ip,
    input  logic [IP_W-1:0]      target_ip,

    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [1:0]           action,
    output logic [MAC_W-1:0]     reply_mac,
    output logic [IP_W-1:0]      reply_ip,
    output logic [SLOT_W-1:0]    slot,
    output logic                 slot_was_new
);

    // configuration registers; own_mac is written by config but drives no output
    logic [MAC_W-1:0] own_mac_reg, own_mac_next;
    logic [IP_W-1:0]  own_ip_reg, own_ip_next;

    item_t   item;
    result_t res;
    logic    res_valid;
    logic    res_ready;

    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        own_mac_next = own_mac_reg;
        own_ip_next  = own_ip_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_OWN_MAC: own_mac_next = cfg_data;
                REG_OWN_IP:  own_ip_next  = cfg_data[IP_W-1:0];
                default:     own_ip_next  = own_ip_reg;
            endcase
        end
    end

    assign item = '{hw_type, proto_type, hw_len, proto_len, opcode,
                    sender_mac, sender_ip, target_ip};

    arpc_ctrl #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .own_ip      (own_ip_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // entry memory: {ip, mac} per slot
    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: load when empty or being drained this cycle
    assign res_ready = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg   <= '0;
            own_ip_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            own_mac_reg   <= own_mac_next;
            own_ip_reg    <= own_ip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign action       = out_reg.action;
    assign reply_mac    = out_reg.reply_mac;
    assign reply_ip     = out_reg.reply_ip;
    assign slot         = out_reg.slot;
    assign slot_was_new = out_reg.slot_was_new;

endmodule

[design/arpc_checker.sv]
// ----------------------------------------------------------------------------
// arpc_checker: port-level assertions for the ARP receive and cache block
// Checks result word consistency and output hold under stall.
// ----------------------------------------------------------------------------
module arpc_checker
    import arpc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input logic [1:0]        action,
    input logic [MAC_W-1:0]  reply_mac,
    input logic [IP_W-1:0]   reply_ip,
    input logic [SLOT_W-1:0] slot,
    input logic              slot_was_new
);

    // hold a stalled word (all fields but reply_mac)
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(action)
            && $stable(slot) && $stable(reply_ip) && $stable(slot_was_new))
        else $error("stalled result word changed");

    a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (action != ACT_REPLY) |-> (reply_mac == '0) && (reply_ip == '0))
        else $error("reply address set on a non-reply result");

    a_slot_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (action != ACT_UPDATED) |-> (slot == '0) && !slot_was_new)
        else $error("slot fields set without a cache update");

    a_new_means_update: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && slot_was_new |-> (action == ACT_UPDATED))
        else $error("new slot flagged on a result other than an update");

endmodule

bind arp_receive_and_cache arpc_checker u_arpc_checker (.*);
